// ===== hdl/led_keyframe_fade_sequencer_unit_defines.svh =====
// Assertion macros for the checker file of the keyframe fade sequencer.
// Depends on nothing; include by bare file name.
`ifndef LED_KEYFRAME_FADE_SEQUENCER_UNIT_DEFINES_SVH
`define LED_KEYFRAME_FADE_SEQUENCER_UNIT_DEFINES_SVH

// Clocked check, switched off while reset is low.
`define LKFS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lkfs: concurrent check failed");

// Clocked check that also holds during reset.
`define LKFS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lkfs: concurrent check failed during reset");

`endif

// ===== hdl/lkfs_pkg.sv =====
// Shared types and constants of the keyframe fade sequencer.
// No dependencies; imported by the divider, the top level, the checker and the bench.
package lkfs_pkg;

    localparam int KF_REGS      = 4;
    localparam int BRIGHT_W     = 8;
    localparam int SEG_W        = 2;
    localparam int COUNT_W      = 3;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 40;
    localparam int FIELD_TIME_W = 16;
    localparam int BRIGHT_LSB   = 0;
    localparam int FADE_LSB     = 8;
    localparam int WAIT_LSB     = 24;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_KF_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KF_FIRST = 3'd1;

    localparam logic PHASE_RAMP = 1'b0;
    localparam logic PHASE_WAIT = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_RD_CUR = 6'b000010,
        S_RD_NXT = 6'b000100,
        S_EVAL   = 6'b001000,
        S_DIV    = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_STEP  = 1'b1
    } mode_t;

endpackage

// ===== hdl/lkfs_divider.sv =====
// Restoring divider, one quotient bit per cycle: time value over brightness difference.
// Depends on lkfs_pkg.
module lkfs_divider
    import lkfs_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TIME_BITS-1:0] dividend,
    input  logic [BRIGHT_W-1:0]  divisor,
    output logic                 done,
    output logic [TIME_BITS-1:0] quotient
);

    localparam int CW = $clog2(TIME_BITS + 1);

    logic [CW-1:0]        cnt_reg,  cnt_next;
    logic                 done_reg, done_next;
    logic [BRIGHT_W:0]    rem_reg,  rem_next;
    logic [TIME_BITS-1:0] quo_reg,  quo_next;
    logic [BRIGHT_W-1:0]  dvs_reg,  dvs_next;
    logic [BRIGHT_W:0]    shifted;
    logic                 fits;

    always_comb
    begin
        shifted   = {rem_reg[BRIGHT_W-1:0], quo_reg[TIME_BITS-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next = CW'(TIME_BITS);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            // shift one dividend bit in, subtract when it fits
            rem_next  = fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next  = {quo_reg[TIME_BITS-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/led_keyframe_fade_sequencer_unit.sv =====
// Top level of the LED keyframe fade sequencer: sequencer, keyframe store, output register.
// Depends on lkfs_pkg and lkfs_divider.
// Usage:
//   Slave stream (s_*) carries one word per millisecond: tick in bit 0. A word with tick
//   low holds all state and still produces a result word.
//   Master stream (m_*) returns exactly one word per input word: the brightness level,
//   the running segment and the phase (ramp or wait), all taken after the update.
//   Configuration: pulse cfg_we with cfg_index/cfg_data. Index 0 is the keyframe count,
//   indexes 1..4 are keyframes 0..3 (bits 7:0 brightness, 23:8 fade, 39:24 wait).
//   Write only while the block is idle.
// Flow: s_tready is low while a word is in work. A held tick or a plain countdown tick
//   goes straight to the emit step. The last hold tick of a level, or a segment start on
//   an equal pair, first makes two keyframe reads from the single-port store. A segment
//   start with a ramp also runs the restoring divider, computing fade / step count one
//   bit per cycle.
// Reset: asynchronous, active low. Clears state to segment 0, ramp phase, level 0,
//   count 1, keyframes 0; the first tick after reset starts segment 0.
// Backpressure: the output register holds a result until m_tready; the next word is
//   still accepted and worked on, and only its result waits in the emit step until the
//   register frees.
module led_keyframe_fade_sequencer_unit
    import lkfs_pkg::*;
#(
    parameter int MAX_KEYFRAMES = 4,
    parameter int TIME_BITS     = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [0] tick, [7:1] zero
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // [7:0] level, [9:8] segment, [10] phase
);

    // Only keyframes below this limit can ever be read.
    localparam int KF_LIMIT = (MAX_KEYFRAMES < KF_REGS) ? MAX_KEYFRAMES : KF_REGS;
    localparam int KF_IW    = (KF_LIMIT > 1) ? $clog2(KF_LIMIT) : 1;
    localparam logic [COUNT_W-1:0] LIMIT_CNT = COUNT_W'(KF_LIMIT);

    // ---------------------------------------------------------------------------------
    // Keyframe store: single read port, registered read data, valid bit per entry so
    // that an entry never written reads as zero.
    // ---------------------------------------------------------------------------------
    logic [CFG_DATA_W-1:0]  kf_mem [KF_LIMIT];
    logic [KF_LIMIT-1:0]    kf_valid_reg;
    logic [CFG_DATA_W-1:0]  rd_data_reg;
    logic [KF_IW-1:0]       rd_addr;
    logic [CFG_INDEX_W-1:0] wr_off;
    logic                   kf_wr;
    logic [KF_IW-1:0]       wr_addr;
    logic [COUNT_W-1:0]     count_reg;

    assign wr_off  = cfg_index - CFG_KF_FIRST;
    assign wr_addr = wr_off[KF_IW-1:0];
    assign kf_wr   = cfg_we && (cfg_index >= CFG_KF_FIRST)
                     && (wr_off < CFG_INDEX_W'(LIMIT_CNT));

    always_ff @(posedge clk)
    begin
        if (kf_wr)
        begin
            kf_mem[wr_addr] <= cfg_data;
        end
        rd_data_reg <= kf_valid_reg[rd_addr] ? kf_mem[rd_addr] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kf_valid_reg <= '0;
            count_reg    <= COUNT_W'(1);
        end
        else
        begin
            if (kf_wr)
            begin
                kf_valid_reg[wr_addr] <= 1'b1;
            end
            if (cfg_we && (cfg_index == CFG_KF_COUNT))
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------------------------
    state_t                state_reg,  state_next;
    mode_t                 mode_reg,   mode_next;
    logic [SEG_W-1:0]      seg_reg,    seg_next;
    logic                  phase_reg,  phase_next;
    logic [BRIGHT_W-1:0]   level_reg,  level_next;
    logic [TIME_BITS-1:0]  hi_reg,     hi_next;     // hold per level
    logic [TIME_BITS-1:0]  ht_reg,     ht_next;     // hold countdown
    logic [TIME_BITS-1:0]  wt_reg,     wt_next;     // wait countdown
    logic [BRIGHT_W-1:0]   cur_bright_reg, cur_bright_next;
    logic [TIME_BITS-1:0]  cur_fade_reg,   cur_fade_next;
    logic [TIME_BITS-1:0]  cur_wait_reg,   cur_wait_next;
    logic                  m_tvalid_reg,   m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg,    m_tdata_next;

    logic [COUNT_W-1:0]    used_cnt;
    logic [COUNT_W-1:0]    seg_inc;
    logic [SEG_W-1:0]      seg_after;
    logic                  accept;
    logic                  out_free;
    logic [BRIGHT_W-1:0]   rd_bright;
    logic [BRIGHT_W-1:0]   diff;
    logic [BRIGHT_W-1:0]   step_level;
    logic                  div_start;
    logic                  div_done;
    logic [TIME_BITS-1:0]  div_quot;
    logic [TIME_BITS-1:0]  hold_sat;

    // Clamp the count to 1..limit, then wrap the successor of the running segment.
    always_comb
    begin
        used_cnt = count_reg;
        if (used_cnt == '0)
        begin
            used_cnt = COUNT_W'(1);
        end
        if (used_cnt > LIMIT_CNT)
        begin
            used_cnt = LIMIT_CNT;
        end
        seg_inc   = COUNT_W'(seg_reg) + COUNT_W'(1);
        seg_after = (seg_inc >= used_cnt) ? '0 : seg_inc[SEG_W-1:0];
    end

    assign rd_addr    = (state_reg == S_RD_CUR) ? seg_reg[KF_IW-1:0] : seg_after[KF_IW-1:0];
    assign rd_bright  = rd_data_reg[BRIGHT_LSB +: BRIGHT_W];
    assign diff       = (cur_bright_reg > rd_bright) ? (cur_bright_reg - rd_bright)
                                                     : (rd_bright - cur_bright_reg);
    assign step_level = (level_reg < rd_bright) ? (level_reg + 1'b1)
                      : (level_reg > rd_bright) ? (level_reg - 1'b1) : level_reg;
    assign hold_sat   = (div_quot == '0) ? TIME_BITS'(1) : div_quot;
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        seg_next        = seg_reg;
        phase_next      = phase_reg;
        level_next      = level_reg;
        hi_next         = hi_reg;
        ht_next         = ht_reg;
        wt_next         = wt_reg;
        cur_bright_next = cur_bright_reg;
        cur_fade_next   = cur_fade_reg;
        cur_wait_next   = cur_wait_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EMIT;
                    if (s_tdata[0])
                    begin
                        if (phase_reg == PHASE_WAIT)
                        begin
                            if (wt_reg > TIME_BITS'(1))
                            begin
                                wt_next = wt_reg - 1'b1;
                            end
                            else
                            begin
                                // wait over: start the following segment
                                seg_next   = seg_after;
                                mode_next  = MODE_START;
                                state_next = S_RD_CUR;
                            end
                        end
                        else if (ht_reg == '0)
                        begin
                            // start pending on the current segment
                            mode_next  = MODE_START;
                            state_next = S_RD_CUR;
                        end
                        else
                        begin
                            ht_next = ht_reg - 1'b1;
                            if (ht_reg == TIME_BITS'(1))
                            begin
                                mode_next  = MODE_STEP;
                                state_next = S_RD_CUR;
                            end
                        end
                    end
                end
            end
            S_RD_CUR:
            begin
                state_next = S_RD_NXT;
            end
            S_RD_NXT:
            begin
                // current keyframe arrives; next keyframe read is in flight
                cur_bright_next = rd_data_reg[BRIGHT_LSB +: BRIGHT_W];
                cur_fade_next   = TIME_BITS'(rd_data_reg[FADE_LSB +: FIELD_TIME_W]);
                cur_wait_next   = TIME_BITS'(rd_data_reg[WAIT_LSB +: FIELD_TIME_W]);
                state_next      = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_EMIT;
                if (mode_reg == MODE_START)
                begin
                    if (cur_bright_reg == rd_bright)
                    begin
                        // equal pair: skip the ramp, level untouched
                        phase_next = PHASE_WAIT;
                        wt_next    = cur_wait_reg;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else if (step_level == rd_bright)
                begin
                    // target reached: never write it, go to the wait
                    phase_next = PHASE_WAIT;
                    wt_next    = cur_wait_reg;
                end
                else
                begin
                    level_next = step_level;
                    ht_next    = hi_reg;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    phase_next = PHASE_RAMP;
                    level_next = cur_bright_reg;
                    hi_next    = hold_sat;
                    ht_next    = hold_sat;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({phase_reg, seg_reg, level_reg});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    lkfs_divider #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cur_fade_reg),
        .divisor  (diff),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= MODE_START;
            seg_reg      <= '0;
            phase_reg    <= PHASE_RAMP;
            level_reg    <= '0;
            hi_reg       <= TIME_BITS'(1);
            ht_reg       <= '0;
            wt_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            seg_reg      <= seg_next;
            phase_reg    <= phase_next;
            level_reg    <= level_next;
            hi_reg       <= hi_next;
            ht_reg       <= ht_next;
            wt_reg       <= wt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_bright_reg <= cur_bright_next;
        cur_fade_reg   <= cur_fade_next;
        cur_wait_reg   <= cur_wait_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/lkfs_checker.sv =====
// Port-level checks of the keyframe fade sequencer, bound to the top level.
// Depends on led_keyframe_fade_sequencer_unit_defines.svh and lkfs_pkg.
`include "led_keyframe_fade_sequencer_unit_defines.svh"

module lkfs_checker
    import lkfs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result word stays put
    `LKFS_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // one word in work at a time: busy right after an accept
    `LKFS_ASSERT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready |=> !s_tready)

    // no result word shows while reset is held
    `LKFS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_tvalid)

endmodule

bind led_keyframe_fade_sequencer_unit lkfs_checker u_lkfs_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for led_keyframe_fade_sequencer_unit: tick words in, status words out.
// Depends on lkfs_pkg and the sequencer RTL; a fade tracker class predicts every status word.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lkfs_pkg::*;

    // Register indexes, named once so the stimulus never spells a bare index.
    localparam logic [CFG_INDEX_W-1:0] CFG_KF0   = CFG_KF_FIRST;
    localparam logic [CFG_INDEX_W-1:0] CFG_KF1   = CFG_INDEX_W'(CFG_KF_FIRST + 1);
    localparam logic [CFG_INDEX_W-1:0] CFG_KF2   = CFG_INDEX_W'(CFG_KF_FIRST + 2);
    localparam logic [CFG_INDEX_W-1:0] CFG_KF3   = CFG_INDEX_W'(CFG_KF_FIRST + 3);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = CFG_INDEX_W'(CFG_KF_FIRST + KF_REGS);
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST  = '1;

    // Print cap so a badly broken build cannot flood the log.
    localparam int PRINT_CAP = 200;

    // One status word as the block reports it after the tick is applied.
    typedef struct packed {
        logic [BRIGHT_W-1:0] level;
        logic [SEG_W-1:0]    segment;
        logic                phase;
    } fade_status_t;

    // Tracks the sequencer state word by word and holds the status words still owed.
    class fade_tracker;
        logic [COUNT_W-1:0]      kf_count;
        logic [CFG_DATA_W-1:0]   kf_word [KF_REGS];
        logic [SEG_W-1:0]        seg;
        logic                    ph;
        logic [BRIGHT_W-1:0]     lvl;
        logic [FIELD_TIME_W-1:0] hold_len;
        logic [FIELD_TIME_W-1:0] hold_left;
        logic [FIELD_TIME_W-1:0] wait_left;
        fade_status_t            due_status [$];
        int                      mismatches;

        function new();
            kf_count = COUNT_W'(1);
            foreach (kf_word[i]) kf_word[i] = '0;
            seg        = '0;
            ph         = PHASE_RAMP;
            lvl        = '0;
            hold_len   = FIELD_TIME_W'(1);
            hold_left  = '0;
            wait_left  = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_KF_COUNT)
                kf_count = value[COUNT_W-1:0];
            else if (idx >= CFG_KF_FIRST && idx < CFG_SPARE)
                kf_word[SEG_W'(idx - CFG_KF_FIRST)] = value;
        endfunction

        // Zero acts as one; anything above the store size saturates.
        function int unsigned used_count();
            int unsigned n;
            n = kf_count;
            if (n < 1) n = 1;
            if (n > KF_REGS) n = KF_REGS;
            return n;
        endfunction

        function logic [SEG_W-1:0] next_of(logic [SEG_W-1:0] k);
            int unsigned n;
            n = k + 1;
            if (n >= used_count()) n = 0;
            return SEG_W'(n);
        endfunction

        function logic [BRIGHT_W-1:0] bright_of(logic [SEG_W-1:0] k);
            return kf_word[k][BRIGHT_LSB +: BRIGHT_W];
        endfunction

        function logic [FIELD_TIME_W-1:0] fade_of(logic [SEG_W-1:0] k);
            return kf_word[k][FADE_LSB +: FIELD_TIME_W];
        endfunction

        function void enter_wait();
            ph        = PHASE_WAIT;
            wait_left = kf_word[seg][WAIT_LSB +: FIELD_TIME_W];
        endfunction

        // Load a segment from the live registers; an equal pair goes straight to the wait.
        function void open_segment(logic [SEG_W-1:0] k);
            logic [BRIGHT_W-1:0] from_b;
            logic [BRIGHT_W-1:0] to_b;
            int unsigned         span;
            int unsigned         per_level;
            seg    = k;
            from_b = bright_of(seg);
            to_b   = bright_of(next_of(seg));
            if (from_b == to_b) begin
                enter_wait();
                return;
            end
            span      = (from_b > to_b) ? from_b - to_b : to_b - from_b;
            per_level = fade_of(seg) / span;
            if (per_level < 1) per_level = 1;
            ph        = PHASE_RAMP;
            lvl       = from_b;
            hold_len  = FIELD_TIME_W'(per_level);
            hold_left = hold_len;
        endfunction

        // Apply one accepted tick word and queue the status it must produce.
        function void note_tick(logic tick);
            logic [BRIGHT_W-1:0] target;
            logic [BRIGHT_W-1:0] stepped;
            if (tick) begin
                if (ph == PHASE_RAMP) begin
                    if (hold_left == 0) begin
                        open_segment(seg);
                    end else begin
                        hold_left--;
                        if (hold_left == 0) begin
                            target  = bright_of(next_of(seg));
                            stepped = lvl;
                            if (stepped < target) stepped++;
                            else if (stepped > target) stepped--;
                            // The target value itself is never shown: reaching it ends the ramp.
                            if (stepped == target) begin
                                enter_wait();
                            end else begin
                                lvl       = stepped;
                                hold_left = hold_len;
                            end
                        end
                    end
                end else if (wait_left > 1) begin
                    wait_left--;
                end else begin
                    open_segment(next_of(seg));
                end
            end
            due_status.push_back('{level: lvl, segment: seg, phase: ph});
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Compare one accepted status word with the oldest one owed.
        task check_word(logic [M_TDATA_W-1:0] word);
            fade_status_t due;
            if (due_status.size() == 0) begin
                report($sformatf("status word %h with nothing owed", word));
                return;
            end
            due = due_status.pop_front();
            if (word[BRIGHT_W-1:0] !== due.level)
                report($sformatf("level %h, want %h", word[BRIGHT_W-1:0], due.level));
            if (word[BRIGHT_W +: SEG_W] !== due.segment)
                report($sformatf("segment %h, want %h", word[BRIGHT_W +: SEG_W], due.segment));
            if (word[BRIGHT_W + SEG_W] !== due.phase)
                report($sformatf("phase %b, want %b", word[BRIGHT_W + SEG_W], due.phase));
        endtask
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b1;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // [0] tick, upper bits zero
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // [7:0] level, [9:8] segment, [10] phase

    fade_tracker         tracker = new();
    bit                  calm         = 1'b0;   // final stretch: no gaps, no stalls
    int                  tx_gap_pct   = 0;
    int                  rx_stall_pct = 0;
    int                  stall_left   = 0;
    int                  words_sent   = 0;
    logic [BRIGHT_W-1:0] bright_base  = '0;

    led_keyframe_fade_sequencer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Output side: drop tready in bursts of random length, hold it high when calm.
    always @(posedge clk)
    begin
        if (!rst_n || calm || rx_stall_pct == 0) begin
            m_tready <= 1'b1;
        end else if (!m_tready) begin
            if (stall_left <= 1) m_tready <= 1'b1;
            else stall_left <= stall_left - 1;
        end else if ($urandom_range(1, 100) <= rx_stall_pct) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(1, 7);
        end
    end

    // Values seen right after the edge are the ones the edge sampled, so the check is race free.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) tracker.check_word(m_tdata);
    end

    function automatic logic [CFG_DATA_W-1:0] make_keyframe(
        input logic [BRIGHT_W-1:0]     bright,
        input logic [FIELD_TIME_W-1:0] fade_ticks,
        input logic [FIELD_TIME_W-1:0] wait_ticks
    );
        logic [CFG_DATA_W-1:0] word;
        word = '0;
        word[BRIGHT_LSB +: BRIGHT_W]   = bright;
        word[FADE_LSB +: FIELD_TIME_W] = fade_ticks;
        word[WAIT_LSB +: FIELD_TIME_W] = wait_ticks;
        return word;
    endfunction

    // Mostly nearby brightness with short fades and waits, so segments wrap often.
    function automatic logic [CFG_DATA_W-1:0] random_keyframe();
        logic [BRIGHT_W-1:0]     bright;
        logic [FIELD_TIME_W-1:0] fade_ticks;
        logic [FIELD_TIME_W-1:0] wait_ticks;
        case ($urandom_range(0, 11))
            0:       bright = '0;
            1:       bright = '1;
            default: bright = bright_base + BRIGHT_W'($urandom_range(0, 10));
        endcase
        fade_ticks = ($urandom_range(0, 9) == 0) ? FIELD_TIME_W'($urandom_range(0, 300))
                                                 : FIELD_TIME_W'($urandom_range(0, 24));
        wait_ticks = ($urandom_range(0, 9) == 0) ? FIELD_TIME_W'($urandom_range(0, 40))
                                                 : FIELD_TIME_W'($urandom_range(0, 5));
        return make_keyframe(bright, fade_ticks, wait_ticks);
    endfunction

    // Write one register at the next edge; callers drop cfg_we after the last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        tracker.write_reg(idx, value);
        @(posedge clk);
    endtask

    // Offer one tick word, maybe after a gap, and hold it until accepted.
    task automatic send_tick(input logic tick);
        if (!calm && $urandom_range(1, 100) <= tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(tick);
        do @(posedge clk); while (!s_tready);
        tracker.note_tick(tick);
        words_sent++;
    endtask

    // Hold off the sender until every owed status word is back; the block is idle then.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.due_status.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int guard;
        int phase_no;
        // Assert reset with a real falling edge so the block clears before the first clock.
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_gap_pct   = 25;
        rx_stall_pct = 25;

        // Reset registers: one keyframe, an equal pair with zero wait, so every tick restarts.
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);

        // Longest fade: 255 down toward 0 over 0xFFFF ticks gives 257 ticks per level.
        // Start segment 1 on an equal pair first, then point keyframe 1 at 0 so
        // segment 0 opens with the full span.
        drain();
        write_reg(CFG_KF_COUNT, CFG_DATA_W'(2));
        write_reg(CFG_KF0, make_keyframe('1, '1, '0));
        write_reg(CFG_KF1, make_keyframe('1, '0, '0));
        cfg_we <= 1'b0;
        send_tick(1'b1);
        drain();
        write_reg(CFG_KF1, make_keyframe('0, '0, '0));
        cfg_we <= 1'b0;
        send_tick(1'b1);
        // Move the target next to 255 so the first step ends the ramp.
        drain();
        write_reg(CFG_KF1, make_keyframe(8'hFE, '0, '0));
        cfg_we <= 1'b0;
        guard = 0;
        while (tracker.seg == '0 && tracker.ph == PHASE_RAMP && guard < 2000) begin
            send_tick($urandom_range(0, 4) != 0);
            guard++;
        end

        // Downward ramp with a hold of two, zero fade on the way back up,
        // and a wait that ends by opening the next segment.
        drain();
        write_reg(CFG_KF_COUNT, CFG_DATA_W'(2));
        write_reg(CFG_KF0, make_keyframe('0, '0, '0));
        write_reg(CFG_KF1, make_keyframe(8'h03, 16'h0006, 16'h0001));
        cfg_we <= 1'b0;
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (11) send_tick(1'b1);

        // Count above the store size saturates; writes past the last keyframe are dropped.
        drain();
        write_reg(CFG_KF_COUNT, CFG_DATA_W'(7));
        write_reg(CFG_KF2, make_keyframe(8'h04, 16'h0003, '0));
        write_reg(CFG_KF3, make_keyframe(8'h05, '0, '1));
        for (int idx = CFG_SPARE; idx <= CFG_LAST; idx++)
            write_reg(CFG_INDEX_W'(idx), '1);
        cfg_we <= 1'b0;
        repeat (4) send_tick(1'b1);

        // Count zero acts as one, leaving the running segment past the count.
        drain();
        write_reg(CFG_KF_COUNT, '0);
        cfg_we <= 1'b0;
        guard = 0;
        do
        begin
            send_tick(1'b1);
            guard++;
        end while (tracker.ph == PHASE_RAMP && guard < 64);

        // Random settings, each phase starting from an idle block.
        phase_no = 0;
        while (words_sent < 760) begin
            drain();
            case ($urandom_range(0, 2))
                0:       tx_gap_pct = 0;
                1:       tx_gap_pct = 15;
                default: tx_gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 15;
                default: rx_stall_pct = 40;
            endcase
            case ($urandom_range(0, 9))
                0:       write_reg(CFG_KF_COUNT, '0);
                1:       write_reg(CFG_KF_COUNT, CFG_DATA_W'($urandom_range(5, 7)));
                default: write_reg(CFG_KF_COUNT, CFG_DATA_W'($urandom_range(1, 4)));
            endcase
            // Count-only phases keep the keyframes, so a shrunken count can strand the segment.
            if (phase_no == 0 || $urandom_range(0, 2) != 0) begin
                bright_base = BRIGHT_W'($urandom);
                for (int k = 0; k < KF_REGS; k++)
                    write_reg(CFG_INDEX_W'(CFG_KF_FIRST + k), random_keyframe());
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(CFG_SPARE, CFG_LAST)),
                          CFG_DATA_W'({$urandom, $urandom}));
            cfg_we <= 1'b0;
            repeat ($urandom_range(30, 90)) send_tick($urandom_range(0, 4) != 0);
            phase_no++;
        end

        // Back-to-back stretch with no idling on either side.
        calm = 1'b1;
        repeat (40) send_tick($urandom_range(0, 4) != 0);
        drain();
        repeat (30) @(posedge clk);
        if (tracker.due_status.size() != 0)
            tracker.report($sformatf("%0d status words never came", tracker.due_status.size()));
        if (tracker.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
